// ===== rtl/core/i2cfcl_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cfcl_pkg
// Shared types and constants of the frame chunk loader.
// ----------------------------------------------------------------------------
package i2cfcl_pkg;

  localparam int unsigned FRAME_BYTES = 192000;
  localparam int unsigned ADDR_W      = 18;
  localparam int unsigned STRIDE_W    = 8;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 8'd123;

  localparam logic [7:0] CMD_CHUNK   = 8'h01;
  localparam logic [7:0] CMD_RENDER  = 8'h02;
  localparam logic [7:0] CMD_NOP     = 8'h03;
  localparam logic [7:0] CMD_ADDR    = 8'h04;
  localparam logic [7:0] CMD_RENDBMP = 8'h05;

  localparam logic [1:0] ACT_BYTE   = 2'd0;
  localparam logic [1:0] ACT_STATUS = 2'd1;
  localparam logic [1:0] ACT_DONE   = 2'd2;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_CHUNK = 3'd1,
    KIND_ADDR  = 3'd2
  } kind_t;

  typedef struct packed {
    logic       transaction_start;
    logic [7:0] data;
    logic [1:0] action;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] received_total;
    logic              bmp_reorder;
    logic              render_pending;
    logic              status_code;
    logic [7:0]        write_data;
    logic [ADDR_W-1:0] write_address;
    logic              write_enable;
  } result_t;

endpackage

// ===== rtl/core/i2cfcl_parser.sv =====
// ----------------------------------------------------------------------------
// i2cfcl_parser
// Transaction parser state and frame-buffer store datapath, one item per take.
// ----------------------------------------------------------------------------
module i2cfcl_parser (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  take,
  input  i2cfcl_pkg::item_t                     item,
  input  logic [i2cfcl_pkg::STRIDE_W-1:0]       chunk_stride,
  output i2cfcl_pkg::result_t                   result
);

  localparam logic [i2cfcl_pkg::ADDR_W-1:0] FRAME_END = i2cfcl_pkg::ADDR_W'(i2cfcl_pkg::FRAME_BYTES);

  i2cfcl_pkg::kind_t                  command_kind, command_kind_next;
  logic [3:0]                         header_count, header_count_next;
  logic [31:0]                        header_shift, header_shift_next;
  logic [i2cfcl_pkg::ADDR_W-1:0]      write_pointer, write_pointer_next;
  logic                               pointer_in_range, pointer_in_range_next;
  logic [i2cfcl_pkg::ADDR_W-1:0]      highest_written, highest_written_next;
  logic                               render_flag, render_flag_next;
  logic                               reorder_flag, reorder_flag_next;
  logic                               rendering_status, rendering_status_next;

  logic [3:0]                         header_len;
  logic [31:0]                        shift_in;
  logic [i2cfcl_pkg::ADDR_W+i2cfcl_pkg::STRIDE_W-1:0] product;
  logic                               chunk_ok;
  logic                               addr_ok;
  logic [i2cfcl_pkg::ADDR_W-1:0]      pointer_inc;
  logic                               we;

  assign shift_in    = {header_shift[23:0], item.data};
  assign product     = shift_in[i2cfcl_pkg::ADDR_W-1:0] * chunk_stride;
  assign chunk_ok    = (chunk_stride == '0) ||
                       ((shift_in[31:i2cfcl_pkg::ADDR_W] == '0) &&
                        (product < (i2cfcl_pkg::ADDR_W+i2cfcl_pkg::STRIDE_W)'(i2cfcl_pkg::FRAME_BYTES)));
  assign addr_ok     = shift_in < 32'(i2cfcl_pkg::FRAME_BYTES);
  assign pointer_inc = write_pointer + 1'b1;

  always_comb begin
    unique case (command_kind)
      i2cfcl_pkg::KIND_CHUNK: header_len = 4'd4;
      i2cfcl_pkg::KIND_ADDR:  header_len = 4'd8;
      default:                header_len = 4'd0;
    endcase
  end

  always_comb begin
    command_kind_next     = command_kind;
    header_count_next     = header_count;
    header_shift_next     = header_shift;
    write_pointer_next    = write_pointer;
    pointer_in_range_next = pointer_in_range;
    highest_written_next  = highest_written;
    render_flag_next      = render_flag;
    reorder_flag_next     = reorder_flag;
    rendering_status_next = rendering_status;
    we                    = 1'b0;

    if (item.action == i2cfcl_pkg::ACT_BYTE) begin
      if (item.transaction_start) begin
        command_kind_next     = i2cfcl_pkg::KIND_NONE;
        header_count_next     = '0;
        header_shift_next     = '0;
        write_pointer_next    = '0;
        pointer_in_range_next = 1'b0;
        unique case (item.data)
          i2cfcl_pkg::CMD_CHUNK: command_kind_next = i2cfcl_pkg::KIND_CHUNK;
          i2cfcl_pkg::CMD_ADDR:  command_kind_next = i2cfcl_pkg::KIND_ADDR;
          i2cfcl_pkg::CMD_RENDER: begin
            render_flag_next  = 1'b1;
            reorder_flag_next = 1'b0;
          end
          i2cfcl_pkg::CMD_RENDBMP: begin
            render_flag_next      = 1'b1;
            reorder_flag_next     = 1'b1;
            rendering_status_next = 1'b1;
          end
          default: ;
        endcase
      end else if (command_kind != i2cfcl_pkg::KIND_NONE) begin
        if (header_count < header_len) begin
          header_shift_next = shift_in;
          header_count_next = header_count + 1'b1;
          if (header_count == 4'd3) begin
            if (command_kind == i2cfcl_pkg::KIND_CHUNK) begin
              pointer_in_range_next = chunk_ok;
              write_pointer_next    = chunk_ok ? product[i2cfcl_pkg::ADDR_W-1:0] : '0;
            end else begin
              pointer_in_range_next = addr_ok;
              write_pointer_next    = addr_ok ? shift_in[i2cfcl_pkg::ADDR_W-1:0] : '0;
            end
          end
        end else if (pointer_in_range) begin
          we                 = 1'b1;
          write_pointer_next = pointer_inc;
          if (pointer_inc > highest_written) begin
            highest_written_next = pointer_inc;
          end
          if (pointer_inc >= FRAME_END) begin
            pointer_in_range_next = 1'b0;
          end
        end
      end
    end else if (item.action == i2cfcl_pkg::ACT_DONE) begin
      render_flag_next      = 1'b0;
      reorder_flag_next     = 1'b0;
      rendering_status_next = 1'b0;
    end
  end

  always_comb begin
    result.write_enable   = we;
    result.write_address  = we ? write_pointer : '0;
    result.write_data     = we ? item.data : '0;
    result.status_code    = rendering_status_next;
    result.render_pending = render_flag_next;
    result.bmp_reorder    = reorder_flag_next;
    result.received_total = highest_written_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      command_kind     <= i2cfcl_pkg::KIND_NONE;
      header_count     <= '0;
      header_shift     <= '0;
      write_pointer    <= '0;
      pointer_in_range <= 1'b0;
      highest_written  <= '0;
      render_flag      <= 1'b0;
      reorder_flag     <= 1'b0;
      rendering_status <= 1'b0;
    end else if (take) begin
      command_kind     <= command_kind_next;
      header_count     <= header_count_next;
      header_shift     <= header_shift_next;
      write_pointer    <= write_pointer_next;
      pointer_in_range <= pointer_in_range_next;
      highest_written  <= highest_written_next;
      render_flag      <= render_flag_next;
      reorder_flag     <= reorder_flag_next;
      rendering_status <= rendering_status_next;
    end
  end

endmodule

// ===== rtl/core/i2c_frame_chunk_loader.sv =====
// ----------------------------------------------------------------------------
// i2c_frame_chunk_loader
// Parses received I2C write bytes into frame-buffer byte stores.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one item per received event: s_tdata is the
//   byte, s_tuser holds the action and the transaction-start flag. Every
//   accepted item yields exactly one item on the master stream with the
//   store request (enable, address, byte) and the current status flags and
//   received total.
//   An accepted item passes through the input register, then the parser
//   pass into the output register that drives m_tvalid.
//   Throughput: one item per cycle while the receiver does not stall; the
//   parser state updates in a single pass per item, so bytes may follow
//   back to back. When the receiver stalls, the output register holds its
//   item and s_tready drops once the input register also holds one.
//   Reset clears the parser state, the flags, the received total and the
//   valid bits of both pipeline registers; chunk_stride returns to 123.
//   The APB port holds chunk_stride at address 0; write it only while idle.
// ----------------------------------------------------------------------------
module i2c_frame_chunk_loader (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data
  input  logic [2:0]  s_tuser,   // [1:0] action, [2] transaction_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [0] write_enable, [18:1] write_address,
                                 // [26:19] write_data, [27] status_code,
                                 // [28] render_pending, [29] bmp_reorder,
                                 // [47:30] received_total
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                                in_valid;
  i2cfcl_pkg::item_t                   in_item;
  logic                                advance;
  logic [i2cfcl_pkg::STRIDE_W-1:0]     chunk_stride;
  i2cfcl_pkg::result_t                 result;

  assign pready   = 1'b1;
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign prdata   = paddr[2] ? '0 : {{(32-i2cfcl_pkg::STRIDE_W){1'b0}}, chunk_stride};

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_stride <= i2cfcl_pkg::STRIDE_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      chunk_stride <= pwdata[i2cfcl_pkg::STRIDE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.action            <= s_tuser[1:0];
      in_item.transaction_start <= s_tuser[2];
      in_item.data              <= s_tdata;
    end
  end

  i2cfcl_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .take         (advance),
    .item         (in_item),
    .chunk_stride (chunk_stride),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= result;
    end
  end

endmodule

// ===== rtl/core/i2cfcl_checker.sv =====
// ----------------------------------------------------------------------------
// i2cfcl_checker
// Port-level checks of the frame chunk loader, bound to the top level.
// ----------------------------------------------------------------------------
module i2cfcl_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output item changed while stalled");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[26:1] == '0)
    else $error("address or data nonzero without a store");

  a_below_total: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[18:1] < m_tdata[47:30])
    else $error("store address not below received total");

  a_total_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[47:30] <= 18'(i2cfcl_pkg::FRAME_BYTES))
    else $error("received total beyond frame");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[27] || m_tdata[29]) |-> m_tdata[28])
    else $error("status or reorder set without a pending render");

endmodule

bind i2c_frame_chunk_loader i2cfcl_checker u_i2cfcl_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
